>>> rtl/smsq_pkg.sv
// Shared types, register indexes and the phase table for the stepper move sequencer.
package smsq_pkg;

    localparam int unsigned POS_W    = 16;
    localparam int unsigned TICK_W   = 32;
    localparam int unsigned COIL_W   = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 2'd1;

    localparam logic [POS_W-1:0]  STEPS_PER_REV_RST = 16'd2038;
    localparam logic [TICK_W-1:0] STEP_INTERVAL_RST = 32'd10;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_MOVE = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [POS_W-1:0]  remaining;
        logic              forward;
        logic [TICK_W-1:0] ticks;
    } smsq_state_t;

    typedef struct packed {
        logic [POS_W-1:0]  steps_per_rev;
        logic [TICK_W-1:0] step_interval;
    } smsq_cfg_t;

    typedef struct packed {
        logic [COIL_W-1:0] coils;
        logic [POS_W-1:0]  position;
        logic              stepped;
        logic              busy;
    } smsq_result_t;

    // full-step drive pattern for position mod 4
    function automatic logic [COIL_W-1:0] phase_coils(input logic [1:0] phase);
        logic [COIL_W-1:0] c;
        case (phase)
            2'd0:    c = 4'd5;
            2'd1:    c = 4'd6;
            2'd2:    c = 4'd10;
            2'd3:    c = 4'd9;
            default: c = 4'd5;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/stepper_move_sequencer_core.sv
// Top level: four-phase full-step stepper move sequencer with config port.
// The result of a transaction is registered and appears in the cycle after it is accepted.
// Throughput: one transaction per cycle; in_ready drops only while a result is held.
// The step, wrap and phase lookup are one combinational pass into the result register.
// Reset: position, remaining steps, tick count zero, direction reverse, no result held;
// steps_per_rev = 2038, step_interval = 10.
module stepper_move_sequencer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic signed [15:0]                  move_steps,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [smsq_pkg::COIL_W-1:0]         coils,
    output logic [smsq_pkg::POS_W-1:0]          position,
    output logic                                stepped,
    output logic                                busy_res,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [smsq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [smsq_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import smsq_pkg::*;

    smsq_state_t  state_reg;
    smsq_state_t  state_next;
    smsq_cfg_t    cfg_reg;
    smsq_result_t res_reg;
    smsq_result_t res_next;
    logic         out_valid_reg;
    logic         in_accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    smsq_step u_step (
        .st         (state_reg),
        .cfg        (cfg_reg),
        .kind       (kind),
        .move_steps (move_steps),
        .st_next    (state_next),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= '0;
            cfg_reg.steps_per_rev <= STEPS_PER_REV_RST;
            cfg_reg.step_interval <= STEP_INTERVAL_RST;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_STEPS_PER_REV: cfg_reg.steps_per_rev <= cfg_data[POS_W-1:0];
                    REG_STEP_INTERVAL: cfg_reg.step_interval <= cfg_data[TICK_W-1:0];
                    default:           ;
                endcase
            end
            if (in_accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign coils     = res_reg.coils;
    assign position  = res_reg.position;
    assign stepped   = res_reg.stepped;
    assign busy_res  = res_reg.busy;

endmodule

>>> rtl/smsq_step.sv
// Next-state and result logic for one tick or move transaction.
module smsq_step (
    input  smsq_pkg::smsq_state_t  st,
    input  smsq_pkg::smsq_cfg_t    cfg,
    input  logic                   kind,
    input  logic signed [15:0]     move_steps,
    output smsq_pkg::smsq_state_t  st_next,
    output smsq_pkg::smsq_result_t res
);
    import smsq_pkg::*;

    smsq_state_t      pre;
    logic [POS_W-1:0] wrap;
    logic [POS_W:0]   pos_inc;
    logic [POS_W-1:0] pos_adv;
    logic             do_step;

    always_comb
    begin
        pre = st;
        if (kind == KIND_TICK)
        begin
            if (st.ticks != '1)
            begin
                pre.ticks = st.ticks + 1'b1;
            end
        end
        else
        begin
            if (move_steps[15])
            begin
                pre.remaining = ~$unsigned(move_steps) + 1'b1;
                pre.forward   = 1'b0;
            end
            else
            begin
                pre.remaining = $unsigned(move_steps);
                if (move_steps != '0)
                begin
                    pre.forward = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        wrap    = (cfg.steps_per_rev == '0) ? POS_W'(1) : cfg.steps_per_rev;
        pos_inc = {1'b0, pre.position} + 1'b1;
        if (pre.forward)
        begin
            pos_adv = (pos_inc >= {1'b0, wrap}) ? '0 : pos_inc[POS_W-1:0];
        end
        else if (pre.position == '0 || pre.position >= wrap)
        begin
            pos_adv = wrap - 1'b1;
        end
        else
        begin
            pos_adv = pre.position - 1'b1;
        end
    end

    always_comb
    begin
        do_step = (pre.remaining != '0) && (pre.ticks >= cfg.step_interval);
        st_next = pre;
        if (do_step)
        begin
            st_next.ticks     = '0;
            st_next.position  = pos_adv;
            st_next.remaining = pre.remaining - 1'b1;
        end
        res.coils    = phase_coils(st_next.position[1:0]);
        res.position = st_next.position;
        res.stepped  = do_step;
        res.busy     = (st_next.remaining != '0);
    end

endmodule

>>> rtl/smsq_checker.sv
// Port-level assertions for the stepper move sequencer, bound to the top level.
module smsq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  coils,
    input logic [15:0] position
);

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result held");

    a_coils_match_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((position[1:0] == 2'd0 && coils == 4'd5)
                    || (position[1:0] == 2'd1 && coils == 4'd6)
                    || (position[1:0] == 2'd2 && coils == 4'd10)
                    || (position[1:0] == 2'd3 && coils == 4'd9)))
        else $error("coil pattern does not match position");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> position != 16'hFFFF)
        else $error("position out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(coils) && $stable(position))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid after reset");

endmodule

bind stepper_move_sequencer_core smsq_checker u_smsq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .coils     (coils),
    .position  (position)
);
